// ----- rtl/core/fet_pkg.sv -----
// ============================================================================
// fet_pkg - shared types and constants for the escape-time iterator
// Fixed-point word types, payload structs, register and mode codes, and the
// saturating helpers used by the sequencer and the multiplier unit.
// ============================================================================
package fet_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 26;
    localparam int PIX_BITS   = 12;
    localparam int CNT_BITS   = 16;
    localparam int WIDE_BITS  = 2 * COORD_BITS;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [WIDE_BITS-1:0]  t_wide;
    typedef logic [CNT_BITS-1:0]          t_count;
    typedef logic [PIX_BITS-1:0]          t_pixel;

    typedef struct packed {
        t_pixel column;
        t_pixel row;
    } t_in_item;

    typedef struct packed {
        t_count iteration_count;
        logic   inside_set;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_MAX_ITER  = 3'd1,
        REG_ORIGIN_RE = 3'd2,
        REG_ORIGIN_IM = 3'd3,
        REG_STEP_RE   = 3'd4,
        REG_STEP_IM   = 3'd5,
        REG_SEED_RE   = 3'd6,
        REG_SEED_IM   = 3'd7
    } t_reg_idx;

    localparam logic [1:0] MODE_QUAD  = 2'd0;
    localparam logic [1:0] MODE_CUBIC = 2'd1;
    localparam logic [1:0] MODE_JULIA = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_RE,
        ST_MAP_IM,
        ST_MAP_END,
        ST_SQ_XX,
        ST_SQ_YY,
        ST_SQ_XY,
        ST_SQ_END,
        ST_CU_TERM,
        ST_CU_X,
        ST_CU_Y,
        ST_CU_END,
        ST_DONE
    } t_state;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord FOUR_Q    = (FRAC_BITS + 3 <= COORD_BITS) ?
                                   COORD_BITS'(64'd4 << FRAC_BITS) : COORD_MAX;

    localparam logic [1:0] RST_MODE      = MODE_QUAD;
    localparam t_count     RST_MAX_ITER  = CNT_BITS'(1000);
    localparam t_coord     RST_ORIGIN_RE = COORD_BITS'(-64'sd167772160);
    localparam t_coord     RST_ORIGIN_IM = COORD_BITS'(-64'sd67108864);
    localparam t_coord     RST_STEP_RE   = COORD_BITS'(64'sd367575);
    localparam t_coord     RST_STEP_IM   = COORD_BITS'(64'sd280204);
    localparam t_coord     RST_SEED_RE   = '0;
    localparam t_coord     RST_SEED_IM   = '0;

    function automatic t_coord sat_wide(input t_wide v);
        if (!v[WIDE_BITS-1] && (|v[WIDE_BITS-2:COORD_BITS-1])) begin
            return COORD_MAX;
        end else if (v[WIDE_BITS-1] && !(&v[WIDE_BITS-2:COORD_BITS-1])) begin
            return COORD_MIN;
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_coord add_sat(input t_coord a, input t_coord b);
        logic [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        if (s[COORD_BITS] != s[COORD_BITS-1]) begin
            return s[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_BITS-1:0];
    endfunction

    function automatic t_coord sub_sat(input t_coord a, input t_coord b);
        logic [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (s[COORD_BITS] != s[COORD_BITS-1]) begin
            return s[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_BITS-1:0];
    endfunction

    function automatic t_coord dbl_sat(input t_coord a);
        if (a[COORD_BITS-1] != a[COORD_BITS-2]) begin
            return a[COORD_BITS-1] ? COORD_MIN : COORD_MAX;
        end
        return {a[COORD_BITS-2:0], 1'b0};
    endfunction

    function automatic t_coord tri_sat(input t_coord a);
        logic [COORD_BITS+1:0] e;
        logic [COORD_BITS+1:0] s;
        e = {{2{a[COORD_BITS-1]}}, a};
        s = e + {e[COORD_BITS:0], 1'b0};
        if ((s[COORD_BITS+1] != s[COORD_BITS]) || (s[COORD_BITS] != s[COORD_BITS-1])) begin
            return s[COORD_BITS+1] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/fractal_escape_time_iterator.sv -----
// ============================================================================
// fractal_escape_time_iterator - escape-time iteration for one pixel at a time
// Maps a pixel to a Q6.26 point and iterates the quadratic, cubic or Julia map
// on one shared multiplier until escape or the iteration limit.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_in_data  (column, row)
//   out       output     o_out_valid / i_out_ready o_out_data (count, inside)
//   config    input      APB psel/penable/pwrite   paddr, pwdata / prdata
//
// Per pixel: ST_IDLE takes it, ST_MAP_RE, ST_MAP_IM and ST_MAP_END map it, then
// each iteration runs SQ_XX, SQ_YY, SQ_XY and then SQ_END (quadratic, Julia) or
// CU_TERM, CU_X, CU_Y, CU_END (cubic), one multiplier pass per product.
// Reset is synchronous; configuration returns to its defaults, no clearing pass.
// One result is held in the output register; the next pixel is taken meanwhile,
// and a second finished result waits in the done state until that one is taken.
// ============================================================================
module fractal_escape_time_iterator
    import fet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data
);

    logic [1:0] r_mode;
    t_count     r_max_iter;
    t_coord     r_origin_re;
    t_coord     r_origin_im;
    t_coord     r_step_re;
    t_coord     r_step_im;
    t_coord     r_seed_re;
    t_coord     r_seed_im;

    t_state     r_state, n_state;
    t_pixel     r_col, r_row;
    t_coord     r_x, n_x;
    t_coord     r_y, n_y;
    t_coord     r_cr, n_cr;
    t_coord     r_ci, n_ci;
    t_coord     r_xx, n_xx;
    t_coord     r_yy, n_yy;
    t_coord     r_t1, n_t1;
    t_coord     r_t2, n_t2;
    t_coord     r_nr, n_nr;
    t_count     r_count, n_count;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    t_coord     op_a, op_b;
    t_coord     mul_frac, mul_whole;
    t_coord     mag;
    logic       cfg_write;
    logic       in_accept;

    fet_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_frac  (mul_frac),
        .o_whole (mul_whole)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_MODE;
            r_max_iter  <= RST_MAX_ITER;
            r_origin_re <= RST_ORIGIN_RE;
            r_origin_im <= RST_ORIGIN_IM;
            r_step_re   <= RST_STEP_RE;
            r_step_im   <= RST_STEP_IM;
            r_seed_re   <= RST_SEED_RE;
            r_seed_im   <= RST_SEED_IM;
        end else if (cfg_write) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_MODE:      r_mode      <= pwdata[1:0];
                REG_MAX_ITER:  r_max_iter  <= pwdata[CNT_BITS-1:0];
                REG_ORIGIN_RE: r_origin_re <= pwdata[COORD_BITS-1:0];
                REG_ORIGIN_IM: r_origin_im <= pwdata[COORD_BITS-1:0];
                REG_STEP_RE:   r_step_re   <= pwdata[COORD_BITS-1:0];
                REG_STEP_IM:   r_step_im   <= pwdata[COORD_BITS-1:0];
                REG_SEED_RE:   r_seed_re   <= pwdata[COORD_BITS-1:0];
                REG_SEED_IM:   r_seed_im   <= pwdata[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_MODE:      prdata = {{(DATA_BITS-2){1'b0}}, r_mode};
            REG_MAX_ITER:  prdata = {{(DATA_BITS-CNT_BITS){1'b0}}, r_max_iter};
            REG_ORIGIN_RE: prdata = r_origin_re;
            REG_ORIGIN_IM: prdata = r_origin_im;
            REG_STEP_RE:   prdata = r_step_re;
            REG_STEP_IM:   prdata = r_step_im;
            REG_SEED_RE:   prdata = r_seed_re;
            REG_SEED_IM:   prdata = r_seed_im;
            default:       prdata = '0;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign mag         = add_sat(r_xx, mul_frac);

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_xx        = r_xx;
        n_yy        = r_yy;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_nr        = r_nr;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        op_a        = '0;
        op_b        = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_MAP_RE;
                end
            end
            ST_MAP_RE: begin
                op_a    = {{(COORD_BITS-PIX_BITS){1'b0}}, r_col};
                op_b    = r_step_re;
                n_state = ST_MAP_IM;
            end
            ST_MAP_IM: begin
                op_a    = {{(COORD_BITS-PIX_BITS){1'b0}}, r_row};
                op_b    = r_step_im;
                n_cr    = add_sat(r_origin_re, mul_whole);
                n_state = ST_MAP_END;
            end
            ST_MAP_END: begin
                n_count = '0;
                if (r_mode == MODE_JULIA) begin
                    n_x  = r_cr;
                    n_y  = add_sat(r_origin_im, mul_whole);
                    n_cr = r_seed_re;
                    n_ci = r_seed_im;
                end else begin
                    n_x  = '0;
                    n_y  = '0;
                    n_ci = add_sat(r_origin_im, mul_whole);
                end
                n_state = ST_SQ_XX;
            end
            ST_SQ_XX: begin
                op_a = r_x;
                op_b = r_x;
                if (r_count == r_max_iter) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SQ_YY;
                end
            end
            ST_SQ_YY: begin
                op_a    = r_y;
                op_b    = r_y;
                n_xx    = mul_frac;
                n_state = ST_SQ_XY;
            end
            ST_SQ_XY: begin
                op_a = r_x;
                op_b = r_y;
                n_yy = mul_frac;
                if (mag > FOUR_Q) begin
                    n_state = ST_DONE;
                end else if (r_mode == MODE_CUBIC) begin
                    n_state = ST_CU_TERM;
                end else begin
                    n_state = ST_SQ_END;
                end
            end
            ST_SQ_END: begin
                n_x     = add_sat(sub_sat(r_xx, r_yy), r_cr);
                n_y     = add_sat(dbl_sat(mul_frac), r_ci);
                n_count = r_count + 1'b1;
                n_state = ST_SQ_XX;
            end
            ST_CU_TERM: begin
                n_t1    = sub_sat(r_xx, tri_sat(r_yy));
                n_t2    = sub_sat(tri_sat(r_xx), r_yy);
                n_state = ST_CU_X;
            end
            ST_CU_X: begin
                op_a    = r_x;
                op_b    = r_t1;
                n_state = ST_CU_Y;
            end
            ST_CU_Y: begin
                op_a    = r_y;
                op_b    = r_t2;
                n_nr    = add_sat(mul_frac, r_cr);
                n_state = ST_CU_END;
            end
            ST_CU_END: begin
                n_x     = r_nr;
                n_y     = add_sat(mul_frac, r_ci);
                n_count = r_count + 1'b1;
                n_state = ST_SQ_XX;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.iteration_count = r_count;
                    n_out.inside_set      = (r_count == r_max_iter);
                    n_out_valid           = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col <= i_in_data.column;
            r_row <= i_in_data.row;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_xx    <= n_xx;
        r_yy    <= n_yy;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_nr    <= n_nr;
        r_count <= n_count;
        r_out   <= n_out;
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_MAP_RE))
        else $error("accepted transaction did not start mapping");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (!r_out_valid || i_out_ready))
        |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished result not loaded into output register");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ_END || r_state == ST_CU_END)
        |=> (r_count == CNT_BITS'($past(r_count) + 1'b1)))
        else $error("iteration count did not advance by one");
`endif

endmodule

// ----- rtl/core/fet_mul_unit.sv -----
// ============================================================================
// fet_mul_unit - shared signed multiplier with registered product
// Registers the exact product each cycle and presents it saturated to the
// coordinate width, both as a whole product and floored by the fraction bits.
// ============================================================================
module fet_mul_unit
    import fet_pkg::*;
(
    input  logic   i_clk,
    input  t_coord i_op_a,
    input  t_coord i_op_b,
    output t_coord o_frac,
    output t_coord o_whole
);

    t_wide r_prod;
    t_wide shifted;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign shifted = r_prod >>> FRAC_BITS;
    assign o_frac  = sat_wide(shifted);
    assign o_whole = sat_wide(r_prod);

endmodule

// ----- dv/tb_fractal_escape_time_iterator.sv -----
// ============================================================================
// tb_fractal_escape_time_iterator - self-checking bench for the escape-time core
// Streams pixels through the valid/ready channels under random idling and a
// long output hold-off. Each accepted pixel is scored against an in-bench
// fixed-point escape-time calculation. The view registers are reprogrammed
// over APB between idle phases, covering every mode, the zero and largest
// limits, saturating geometry and random well-formed views.
// ============================================================================
module tb_fractal_escape_time_iterator;
    import fet_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam t_coord     ONE_Q      = t_coord'(64'sd1 << FRAC_BITS);
    localparam t_coord     THREE_Q    = t_coord'(64'sd3 << FRAC_BITS);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_BITS-1:0] paddr       = '0;
    logic [DATA_BITS-1:0] pwdata      = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;

    logic [1:0] view_mode      = RST_MODE;
    t_count     view_limit     = RST_MAX_ITER;
    t_coord     view_origin_re = RST_ORIGIN_RE;
    t_coord     view_origin_im = RST_ORIGIN_IM;
    t_coord     view_step_re   = RST_STEP_RE;
    t_coord     view_step_im   = RST_STEP_IM;
    t_coord     view_seed_re   = RST_SEED_RE;
    t_coord     view_seed_im   = RST_SEED_IM;

    t_in_item   pending_pixels[$];
    t_out_item  predicted_escapes[$];
    int         mismatches = 0;
    bit         steady     = 1'b0;
    bit         hold_req   = 1'b0;
    bit         hold_taken = 1'b0;
    int         hold_left  = 0;
    int         send_gap   = 0;
    int         take_gap   = 0;

    fractal_escape_time_iterator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_coord clamp_q(input longint v);
        if (v > longint'(COORD_MAX)) return COORD_MAX;
        if (v < longint'(COORD_MIN)) return COORD_MIN;
        return t_coord'(v);
    endfunction

    function automatic t_coord mul_q(input t_coord a, input t_coord b);
        return clamp_q((longint'(a) * longint'(b)) >>> FRAC_BITS);
    endfunction

    function automatic t_coord add_q(input t_coord a, input t_coord b);
        return clamp_q(longint'(a) + longint'(b));
    endfunction

    function automatic t_coord sub_q(input t_coord a, input t_coord b);
        return clamp_q(longint'(a) - longint'(b));
    endfunction

    function automatic t_out_item escape_time(input t_in_item px);
        t_coord      x;
        t_coord      y;
        t_coord      cr;
        t_coord      ci;
        t_coord      xx;
        t_coord      yy;
        t_coord      nr;
        t_coord      ni;
        int unsigned n;
        t_out_item   res;
        cr = add_q(view_origin_re, clamp_q(longint'(px.column) * longint'(view_step_re)));
        ci = add_q(view_origin_im, clamp_q(longint'(px.row) * longint'(view_step_im)));
        x  = '0;
        y  = '0;
        if (view_mode == MODE_JULIA) begin
            x  = cr;
            y  = ci;
            cr = view_seed_re;
            ci = view_seed_im;
        end
        n = 0;
        while (n < view_limit) begin
            xx = mul_q(x, x);
            yy = mul_q(y, y);
            if (add_q(xx, yy) > FOUR_Q) break;
            if (view_mode == MODE_CUBIC) begin
                nr = add_q(mul_q(x, sub_q(xx, clamp_q(3 * longint'(yy)))), cr);
                ni = add_q(mul_q(y, sub_q(clamp_q(3 * longint'(xx)), yy)), ci);
            end else begin
                nr = add_q(sub_q(xx, yy), cr);
                ni = add_q(clamp_q(2 * longint'(mul_q(x, y))), ci);
            end
            x = nr;
            y = ni;
            n++;
        end
        res.iteration_count = t_count'(n);
        res.inside_set      = (n == view_limit);
        return res;
    endfunction

    function automatic int idle_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin : pixel_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_escapes.push_back(escape_time(i_in_data));
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    i_in_data  <= pending_pixels.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap   <= idle_gap(steady);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            take_gap    <= 0;
        end else if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= 4000;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap    <= take_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            take_gap    <= idle_gap(steady);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_escapes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected transaction: count %0d inside %0b",
                             o_out_data.iteration_count, o_out_data.inside_set);
                end
            end else begin
                want = predicted_escapes.pop_front();
                if (o_out_data.iteration_count !== want.iteration_count ||
                    o_out_data.inside_set !== want.inside_set) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: count exp %0d got %0d, inside exp %0b got %0b",
                                 want.iteration_count, o_out_data.iteration_count,
                                 want.inside_set, o_out_data.inside_set);
                    end
                end
            end
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [DATA_BITS-1:0] value);
        logic [DATA_BITS-1:0] readback;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        readback = value;
        case (idx)
            REG_MODE: begin
                view_mode = value[1:0];
                readback  = {{(DATA_BITS-2){1'b0}}, value[1:0]};
            end
            REG_MAX_ITER: begin
                view_limit = value[CNT_BITS-1:0];
                readback   = {{(DATA_BITS-CNT_BITS){1'b0}}, value[CNT_BITS-1:0]};
            end
            REG_ORIGIN_RE: view_origin_re = value;
            REG_ORIGIN_IM: view_origin_im = value;
            REG_STEP_RE:   view_step_re   = value;
            REG_STEP_IM:   view_step_im   = value;
            REG_SEED_RE:   view_seed_re   = value;
            REG_SEED_IM:   view_seed_im   = value;
            default: begin
            end
        endcase
        @(negedge i_clk);
        if (prdata !== readback || pready !== 1'b1) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("register readback: exp %h got %h, pready %0b",
                         readback, prdata, pready);
            end
        end
    endtask

    task automatic set_view(input logic [1:0] mode, input t_count limit,
                            input t_coord ore, input t_coord oim,
                            input t_coord sre, input t_coord sim);
        reg_write(REG_MODE, {30'd0, mode});
        reg_write(REG_MAX_ITER, {16'd0, limit});
        reg_write(REG_ORIGIN_RE, ore);
        reg_write(REG_ORIGIN_IM, oim);
        reg_write(REG_STEP_RE, sre);
        reg_write(REG_STEP_IM, sim);
    endtask

    task automatic queue_pixel(input int unsigned col, input int unsigned row);
        t_in_item px;
        px.column = t_pixel'(col);
        px.row    = t_pixel'(row);
        pending_pixels.push_back(px);
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_pixels.size() != 0 || i_in_valid || predicted_escapes.size() != 0);
    endtask

    function automatic logic [31:0] coord_pick(input bit noisy, input int unsigned span,
                                               input int offset);
        if (noisy) return $urandom();
        return int'($urandom_range(0, span)) + offset;
    endfunction

    function automatic logic [31:0] step_pick(input bit noisy);
        int s;
        if (noisy) return $urandom();
        if ($urandom_range(0, 7) == 0) return '0;
        s = $urandom_range(1, 57000);
        if ($urandom_range(0, 3) == 0) s = -s;
        return s;
    endfunction

    task automatic random_phase(input int unsigned items, input bit calm);
        int unsigned pick;
        logic [1:0]  mode;
        t_count      limit;
        bit          noisy;
        pick  = $urandom_range(0, 9);
        mode  = pick < 3 ? MODE_QUAD : pick < 6 ? MODE_CUBIC : pick < 9 ? MODE_JULIA : MODE_SPARE;
        pick  = $urandom_range(0, 19);
        limit = pick == 0 ? t_count'(1) :
                pick == 1 ? t_count'($urandom_range(100, 255)) : t_count'($urandom_range(2, 48));
        noisy = ($urandom_range(0, 4) == 0);
        reg_write(REG_MODE, ($urandom() & 32'hFFFF_FFFC) | {30'd0, mode});
        reg_write(REG_MAX_ITER, {16'($urandom()), limit});
        reg_write(REG_ORIGIN_RE, coord_pick(noisy, 201326592, -167772160));
        reg_write(REG_ORIGIN_IM, coord_pick(noisy, 134217728, -100663296));
        reg_write(REG_STEP_RE, step_pick(noisy));
        reg_write(REG_STEP_IM, step_pick(noisy));
        reg_write(REG_SEED_RE, coord_pick($urandom_range(0, 5) == 0, 134217728, -67108864));
        reg_write(REG_SEED_IM, coord_pick($urandom_range(0, 5) == 0, 134217728, -67108864));
        steady = calm || ($urandom_range(0, 3) == 0);
        repeat (items) queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        wait_idle();
    endtask

    initial begin : stimulus
        int unsigned random_items;
        int unsigned batch;
        random_items = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        queue_pixel(456, 239);
        queue_pixel(2730, 1365);
        queue_pixel(1365, 2730);
        wait_idle();

        reg_write(REG_MODE, 32'hFFFF_FFFF);
        reg_write(REG_MAX_ITER, 32'h5A5A_0000);
        queue_pixel(0, 0);
        wait_idle();
        reg_write(REG_MAX_ITER, 32'hA5A5_0001);
        queue_pixel(4095, 4095);
        queue_pixel(456, 239);
        wait_idle();

        set_view(MODE_QUAD, 4, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        queue_pixel(4095, 4095);
        queue_pixel(1, 1);
        wait_idle();
        set_view(MODE_CUBIC, 4, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        wait_idle();

        set_view(MODE_JULIA, 32, THREE_Q, THREE_Q, '0, '0);
        reg_write(REG_SEED_RE, COORD_MAX);
        reg_write(REG_SEED_IM, COORD_MIN);
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        wait_idle();

        set_view(MODE_QUAD, 16'hFFFF, '0, '0, ONE_Q, '0);
        queue_pixel(0, 0);
        queue_pixel(3, 17);
        wait_idle();

        hold_req = 1'b1;
        random_phase(40, 1'b1);
        random_items = 40;
        while (random_items < 700) begin
            batch = $urandom_range(30, 60);
            random_phase(batch, 1'b0);
            random_items += batch;
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && predicted_escapes.size() == 0) begin
            $display("tb_fractal_escape_time_iterator: PASS");
        end else begin
            $display("tb_fractal_escape_time_iterator: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #300_000_000;
        $display("tb_fractal_escape_time_iterator: FAIL");
        $finish;
    end

endmodule
